// File: sv/csc_pkg.sv
package csc_pkg;

    // Lexer modes of the first stage.
    typedef enum logic [1:0] {
        MODE_TEXT   = 2'd0,
        MODE_STRING = 2'd1,
        MODE_LINE   = 2'd2,
        MODE_BLOCK  = 2'd3
    } lex_mode_t;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;

    localparam int unsigned CSC_QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_last;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       stream_end;
    } out_word_t;

    // One classified input word: up to two stage-one bytes in order.
    typedef struct packed {
        logic       v0;
        logic [7:0] b0;
        logic       v1;
        logic [7:0] b1;
        logic       last;
    } mid_word_t;

    // Space, TAB, LF, VT, FF and CR.
    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

endpackage

// File: sv/csc_queue.sv
module csc_queue
    import csc_pkg::*;
#(
    parameter type         word_t = mid_word_t,
    parameter int unsigned DEPTH  = CSC_QUEUE_DEPTH
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  word_t wdata,
    output logic  full,
    input  logic  pop,
    output word_t rdata,
    output logic  empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    word_t           mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    // The fill level never exceeds the depth.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(DEPTH))
        else $error("queue fill level above depth");

endmodule

// File: sv/csc_front.sv
module csc_front
    import csc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  in_word_t  in_word,
    input  logic      mid_full,
    output logic      mid_push,
    output mid_word_t mid_word
);

    lex_mode_t  mode_reg, mode_next;
    logic       held_reg, held_next;
    logic       star_reg, star_next;
    logic       bs_reg, bs_next;
    logic [7:0] b;

    assign b        = in_word.in_byte;
    assign mid_push = push && !mid_full;

    always_comb
    begin
        mode_next = mode_reg;
        held_next = held_reg;
        star_next = star_reg;
        mid_word  = '0;

        unique case (mode_reg)
            MODE_STRING:
            begin
                mid_word.v0 = 1'b1;
                mid_word.b0 = b;
                if (b == CH_QUOTE && !bs_reg)
                begin
                    mode_next = MODE_TEXT;
                end
            end
            MODE_LINE:
            begin
                if (b == CH_LF || b == CH_CR)
                begin
                    mode_next   = MODE_TEXT;
                    mid_word.v0 = 1'b1;
                    mid_word.b0 = b;
                end
            end
            MODE_BLOCK:
            begin
                if (star_reg && b == CH_SLASH)
                begin
                    mode_next = MODE_TEXT;
                    star_next = 1'b0;
                end
                else
                begin
                    star_next = (b == CH_STAR);
                end
            end
            MODE_TEXT:
            begin
                if (held_reg)
                begin
                    held_next = 1'b0;
                    if (b == CH_SLASH)
                    begin
                        mode_next = MODE_LINE;
                    end
                    else if (b == CH_STAR)
                    begin
                        mode_next = MODE_BLOCK;
                        star_next = 1'b0;
                    end
                    else
                    begin
                        // The held slash was not a comment opener.
                        mid_word.v0 = 1'b1;
                        mid_word.b0 = CH_SLASH;
                        mid_word.v1 = 1'b1;
                        mid_word.b1 = b;
                        if (b == CH_QUOTE)
                        begin
                            mode_next = MODE_STRING;
                        end
                    end
                end
                else if (b == CH_SLASH)
                begin
                    held_next = 1'b1;
                end
                else
                begin
                    mid_word.v0 = 1'b1;
                    mid_word.b0 = b;
                    if (b == CH_QUOTE)
                    begin
                        mode_next = MODE_STRING;
                    end
                end
            end
        endcase

        bs_next = (b == CH_BSLASH);

        // A slash still held at end of stream goes out as the second byte.
        if (in_word.is_last && held_next)
        begin
            mid_word.v1 = 1'b1;
            mid_word.b1 = CH_SLASH;
        end
        mid_word.last = in_word.is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_TEXT;
            held_reg <= 1'b0;
            star_reg <= 1'b0;
            bs_reg   <= 1'b0;
        end
        else if (mid_push)
        begin
            if (in_word.is_last)
            begin
                mode_reg <= MODE_TEXT;
                held_reg <= 1'b0;
                star_reg <= 1'b0;
                bs_reg   <= 1'b0;
            end
            else
            begin
                mode_reg <= mode_next;
                held_reg <= held_next;
                star_reg <= star_next;
                bs_reg   <= bs_next;
            end
        end
    end

    // A slash is only ever held in text mode.
    assert property (@(posedge clk) disable iff (!rst_n) held_reg |-> mode_reg == MODE_TEXT)
        else $error("slash held outside text mode");

    // The word that ends a stream returns the lexer to its reset state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mid_push && in_word.is_last) |=> (mode_reg == MODE_TEXT && !held_reg && !star_reg))
        else $error("lexer not reset after end of stream");

endmodule

// File: sv/csc_back.sv
module csc_back
    import csc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      mid_empty,
    input  mid_word_t mid_word,
    output logic      mid_pop,
    input  logic      res_full,
    output logic      res_push,
    output out_word_t res_word
);

    logic idx_reg, idx_next;
    logic ps_reg, ps_next;
    logic ws0, ws1, first, e0, e1, ps_mid;

    always_comb
    begin
        ws0    = is_ws(mid_word.b0);
        ws1    = is_ws(mid_word.b1);
        first  = !idx_reg;
        e0     = first && mid_word.v0 && !(ws0 && ps_reg);
        ps_mid = (first && mid_word.v0) ? ws0 : ps_reg;
        e1     = mid_word.v1 && !(ws1 && ps_mid);

        res_push = 1'b0;
        res_word = '0;
        mid_pop  = 1'b0;
        idx_next = idx_reg;
        ps_next  = ps_reg;

        if (!mid_empty)
        begin
            if (e0)
            begin
                res_word.out_byte   = ws0 ? CH_SPACE : mid_word.b0;
                res_word.byte_valid = 1'b1;
                res_word.run_last   = !e1;
                res_word.stream_end = mid_word.last && !e1;
                if (!res_full)
                begin
                    res_push = 1'b1;
                    ps_next  = ws0;
                    if (e1)
                    begin
                        idx_next = 1'b1;
                    end
                    else
                    begin
                        mid_pop  = 1'b1;
                        idx_next = 1'b0;
                        if (mid_word.last)
                        begin
                            ps_next = 1'b0;
                        end
                    end
                end
            end
            else if (e1)
            begin
                res_word.out_byte   = ws1 ? CH_SPACE : mid_word.b1;
                res_word.byte_valid = 1'b1;
                res_word.run_last   = 1'b1;
                res_word.stream_end = mid_word.last;
                if (!res_full)
                begin
                    res_push = 1'b1;
                    mid_pop  = 1'b1;
                    idx_next = 1'b0;
                    ps_next  = mid_word.last ? 1'b0 : ws1;
                end
            end
            else if (mid_word.last)
            begin
                // Nothing survived: send a bare end marker.
                res_word.run_last   = 1'b1;
                res_word.stream_end = 1'b1;
                if (!res_full)
                begin
                    res_push = 1'b1;
                    mid_pop  = 1'b1;
                    idx_next = 1'b0;
                    ps_next  = 1'b0;
                end
            end
            else
            begin
                mid_pop  = 1'b1;
                idx_next = 1'b0;
                ps_next  = ps_mid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 1'b0;
            ps_reg  <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            ps_reg  <= ps_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) res_push |-> !res_full)
        else $error("result written into a full queue");

    // The second byte of a word is pending only while that word is still queued.
    assert property (@(posedge clk) disable iff (!rst_n) idx_reg |-> !mid_empty)
        else $error("second byte pending without a queued word");

    assert property (@(posedge clk) disable iff (!rst_n)
        (mid_pop && mid_word.last) |=> (!ps_reg && !idx_reg))
        else $error("collapse state not reset after end of stream");

endmodule

// File: sv/comment_strip_space_collapse.sv
// Flow: an accepted word is classified into the middle queue, its results are then written into
//   the result queue, and they show on out_word with empty low.
// Throughput: one input word per cycle while each word yields at most one result and neither
//   queue is full; a word with two results holds the back stage, which sends one result per cycle.
// Reset: rst_n is asynchronous and active low; it empties both queues and returns the
//   lexer and the whitespace-collapse state to normal text with nothing held.
module comment_strip_space_collapse
    import csc_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = CSC_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  in_word_t  in_word,
    output logic      full,
    input  logic      pop,
    output out_word_t out_word,
    output logic      empty
);

    // The front stage runs the comment lexer. For every accepted word it
    // places a classified word into the middle queue holding up to two
    // surviving bytes: a held slash that turned out not to open a comment
    // comes out ahead of the byte that followed it, and at end of stream a
    // slash still held is flushed as the second byte.
    mid_word_t mid_wdata;
    mid_word_t mid_rdata;
    logic      mid_push;
    logic      mid_pop;
    logic      mid_full;
    logic      mid_empty;

    // The back stage collapses whitespace runs and hands results, one per
    // cycle while the result queue has room, to the result queue, which lets
    // it keep working while the consumer stalls.
    out_word_t res_wdata;
    logic      res_push;
    logic      res_full;

    // The input side is full exactly when the middle queue cannot take a word.
    assign full = mid_full;

    csc_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .in_word  (in_word),
        .mid_full (mid_full),
        .mid_push (mid_push),
        .mid_word (mid_wdata)
    );

    csc_queue #(
        .word_t (mid_word_t),
        .DEPTH  (QUEUE_DEPTH)
    ) u_mid_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata (mid_wdata),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty)
    );

    csc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_word  (mid_rdata),
        .mid_pop   (mid_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_word  (res_wdata)
    );

    // The oldest result sits at the head of this queue while empty is low.
    csc_queue #(
        .word_t (out_word_t),
        .DEPTH  (QUEUE_DEPTH)
    ) u_res_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_wdata),
        .full  (res_full),
        .pop   (pop),
        .rdata (out_word),
        .empty (empty)
    );

endmodule

// File: dv/clean_stream_check.sv
module clean_stream_check
    import csc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  in_word_t  in_word,
    input  logic      full,
    input  logic      pop,
    input  out_word_t out_word,
    input  logic      empty,
    output int        fail_count,
    output int        pending
);

    // Shadow copy of the lexer and collapse state.
    lex_mode_t  lexer_mode;
    logic       slash_pending;
    logic       star_prev;
    logic       bslash_prev;
    logic       space_prev;

    out_word_t  due_words[$];
    out_word_t  step_out[$];
    int         errors;

    initial begin
        fail_count = 0;
        pending    = 0;
        errors     = 0;
    end

    function automatic logic blank_char(input logic [7:0] b);
        return (b == CH_SPACE) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0B)
            || (b == 8'h0C) || (b == 8'h0D);
    endfunction

    task automatic clear_lexer();
        lexer_mode    = MODE_TEXT;
        slash_pending = 1'b0;
        star_prev     = 1'b0;
        bslash_prev   = 1'b0;
        space_prev    = 1'b0;
    endtask

    // Whitespace collapse: a run of blanks leaves a single space.
    task automatic emit_collapsed(input logic [7:0] b);
        out_word_t w;
        logic      keep;
        keep = 1'b1;
        if (blank_char(b)) begin
            if (space_prev)
                keep = 1'b0;
            space_prev = 1'b1;
            b = CH_SPACE;
        end
        else begin
            space_prev = 1'b0;
        end
        if (keep) begin
            w            = '0;
            w.out_byte   = b;
            w.byte_valid = 1'b1;
            step_out     = {step_out, w};
        end
    endtask

    task automatic text_char(input logic [7:0] b);
        if (b == CH_QUOTE) begin
            lexer_mode = MODE_STRING;
            emit_collapsed(b);
        end
        else if (b == CH_SLASH) begin
            slash_pending = 1'b1;
        end
        else begin
            emit_collapsed(b);
        end
    endtask

    task automatic strip_and_collapse(input in_word_t w);
        logic [7:0] b;
        out_word_t  tail;
        int         tail_idx;
        b = w.in_byte;
        step_out.delete();
        case (lexer_mode)
            MODE_STRING: begin
                emit_collapsed(b);
                if (b == CH_QUOTE && !bslash_prev)
                    lexer_mode = MODE_TEXT;
            end
            MODE_LINE: begin
                if (b == CH_LF || b == CH_CR) begin
                    lexer_mode = MODE_TEXT;
                    emit_collapsed(b);
                end
            end
            MODE_BLOCK: begin
                if (star_prev && b == CH_SLASH) begin
                    lexer_mode = MODE_TEXT;
                    star_prev  = 1'b0;
                end
                else begin
                    star_prev = (b == CH_STAR);
                end
            end
            default: begin
                if (slash_pending) begin
                    slash_pending = 1'b0;
                    if (b == CH_SLASH) begin
                        lexer_mode = MODE_LINE;
                    end
                    else if (b == CH_STAR) begin
                        lexer_mode = MODE_BLOCK;
                        star_prev  = 1'b0;
                    end
                    else begin
                        emit_collapsed(CH_SLASH);
                        text_char(b);
                    end
                end
                else begin
                    text_char(b);
                end
            end
        endcase
        bslash_prev = (b == CH_BSLASH);

        if (w.is_last) begin
            if (slash_pending)
                emit_collapsed(CH_SLASH);
            if (step_out.size() == 0) begin
                tail     = '0;
                step_out = {step_out, tail};
            end
            tail_idx            = step_out.size() - 1;
            tail                = step_out[tail_idx];
            tail.stream_end     = 1'b1;
            step_out[tail_idx]  = tail;
            clear_lexer();
        end
        if (step_out.size() > 0) begin
            tail_idx           = step_out.size() - 1;
            tail               = step_out[tail_idx];
            tail.run_last      = 1'b1;
            step_out[tail_idx] = tail;
        end
        due_words = {due_words, step_out};
    endtask

    always @(posedge clk or negedge rst_n) begin
        out_word_t want;
        if (!rst_n) begin
            clear_lexer();
            due_words.delete();
            pending <= 0;
        end
        else begin
            // Results pass through both queues before they can leave, so the
            // compare can run ahead of this edge's prediction.
            if (pop && !empty) begin
                if (due_words.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected word: byte %h valid %b run_last %b end %b",
                                 out_word.out_byte, out_word.byte_valid,
                                 out_word.run_last, out_word.stream_end);
                end
                else begin
                    want = due_words.pop_front();
                    if (out_word.out_byte !== want.out_byte
                            || out_word.byte_valid !== want.byte_valid
                            || out_word.run_last !== want.run_last
                            || out_word.stream_end !== want.stream_end) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: expected byte %h valid %b run_last %b ",
                                      "end %b, got byte %h valid %b run_last %b end %b"},
                                     want.out_byte, want.byte_valid, want.run_last,
                                     want.stream_end, out_word.out_byte,
                                     out_word.byte_valid, out_word.run_last,
                                     out_word.stream_end);
                    end
                end
            end
            if (push && !full)
                strip_and_collapse(in_word);
            pending <= due_words.size();
        end
        fail_count <= errors;
    end

endmodule

// File: dv/tb_comment_strip_space_collapse.sv
module tb_comment_strip_space_collapse;
    import csc_pkg::*;

    // Cycles without any accepted word before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 1000;
    // Cycles to wait once nothing is outstanding, to catch stray words.
    localparam int TAIL_CYCLES    = 8;
    // Number of words to push in the random part.
    localparam int RANDOM_WORDS   = 600;

    logic      clk     = 1'b0;
    logic      rst_n   = 1'b0;
    logic      push    = 1'b0;
    in_word_t  in_word = '0;
    logic      full;
    logic      pop     = 1'b0;
    out_word_t out_word;
    logic      empty;

    int        fail_count;
    int        pending;

    // When set, neither side inserts idle cycles.
    logic      no_idle = 1'b0;
    int        pop_stall = 0;
    int        quiet_cycles = 0;
    int        words_sent = 0;

    // Raw text of the stream being built by the random generator.
    logic [7:0] text_q[$];

    comment_strip_space_collapse dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .in_word  (in_word),
        .full     (full),
        .pop      (pop),
        .out_word (out_word),
        .empty    (empty)
    );

    // The checker watches both channels, predicts the cleaned stream and
    // reports the number of failures and the number of words still due.
    clean_stream_check stream_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .in_word    (in_word),
        .full       (full),
        .pop        (pop),
        .out_word   (out_word),
        .empty      (empty),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Result side. The receiver stalls in random bursts, unless the
    // current phase asks for a steady drain.
    always @(posedge clk) begin
        if (pop_stall != 0) begin
            pop       <= 1'b0;
            pop_stall <= pop_stall - 1;
        end
        else if (rst_n && !no_idle && $urandom_range(0, 7) == 0) begin
            pop       <= 1'b0;
            pop_stall <= $urandom_range(0, 2);
        end
        else begin
            pop <= 1'b1;
        end
    end

    // Watchdog: any accepted word on either side restarts the count.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((push && !full) || (pop && !empty)) begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_comment_strip_space_collapse: FAIL");
                $finish;
            end
            else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Push one word and hold it until the block takes it. An optional idle
    // burst comes first. The push strobe is left high on acceptance so that
    // back-to-back words never drop it for a step.
    task automatic send_word(input logic [7:0] b, input logic last);
        in_word_t w;
        if (!no_idle && $urandom_range(0, 7) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        w.in_byte = b;
        w.is_last = last;
        push    <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (full)
            @(posedge clk);
        words_sent++;
    endtask

    // Send a literal string; close marks the final character as the end
    // of the stream.
    task automatic send_text(input string s, input logic close);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], close && (i == s.len() - 1));
    endtask

    // Filler biased toward the characters the lexer cares about: slashes,
    // stars, quotes, backslashes and every kind of whitespace.
    function automatic logic [7:0] filler_byte();
        case ($urandom_range(0, 9))
            0:       return CH_SPACE;
            1:       return CH_TAB + 8'($urandom_range(0, 4));
            2:       return CH_SLASH;
            3:       return CH_STAR;
            4:       return CH_QUOTE;
            5:       return CH_BSLASH;
            6:       return 8'($urandom_range(0, 255));
            default: return 8'h61 + 8'($urandom_range(0, 25));
        endcase
    endfunction

    // Append one byte to the stream under construction.
    task automatic add_byte(input logic [7:0] b);
        text_q = {text_q, b};
    endtask

    task automatic add_fillers(input int lo, input int hi);
        repeat ($urandom_range(lo, hi))
            add_byte(filler_byte());
    endtask

    // Build one stream out of mostly well-formed pieces: block comments,
    // line comments, strings with escaped quotes, and plain text. About one
    // piece in six loses its closer, and some pieces are pure noise.
    task automatic build_stream();
        int  pieces;
        logic broken;
        text_q.delete();
        pieces = $urandom_range(1, 8);
        repeat (pieces) begin
            broken = ($urandom_range(0, 5) == 0);
            case ($urandom_range(0, 9))
                0, 1: begin
                    add_byte(CH_SLASH);
                    add_byte(CH_STAR);
                    add_fillers(0, 6);
                    if ($urandom_range(0, 2) == 0)
                        add_byte(CH_STAR);
                    if (!broken) begin
                        add_byte(CH_STAR);
                        add_byte(CH_SLASH);
                    end
                end
                2, 3: begin
                    add_byte(CH_SLASH);
                    add_byte(CH_SLASH);
                    add_fillers(0, 6);
                    if (!broken)
                        add_byte(($urandom_range(0, 1) != 0) ? CH_LF : CH_CR);
                end
                4, 5: begin
                    add_byte(CH_QUOTE);
                    add_fillers(0, 5);
                    if ($urandom_range(0, 2) == 0) begin
                        add_byte(CH_BSLASH);
                        add_byte(CH_QUOTE);
                        add_fillers(0, 3);
                    end
                    if (!broken)
                        add_byte(CH_QUOTE);
                end
                6: begin
                    repeat ($urandom_range(1, 4))
                        add_byte(8'($urandom_range(0, 255)));
                end
                default: begin
                    add_fillers(1, 6);
                end
            endcase
        end
    endtask

    initial begin
        int random_goal;

        // Reset is held low from the start and released on a rising edge.
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed streams.
        // Leading whitespace collapses to one space; a lone slash comes out
        // together with the letter after it.
        send_text(" \tA/B", 1'b1);
        // The star that opens a block comment cannot close it, so the
        // comment runs on to the real closer; then the top byte value.
        send_text("/*/x*/", 1'b0);
        send_word(8'hFF, 1'b1);
        // A string with an escaped quote holds slashes verbatim; then the
        // bottom byte value.
        send_text("\"\\\"//\"", 1'b0);
        send_word(8'h00, 1'b1);
        // A line comment keeps its CR, and a slash held at the end of the
        // stream is flushed.
        send_text("//\015/", 1'b1);
        // A stream ending inside a block comment gives a bare end marker.
        send_text("/*", 1'b1);
        // An unterminated string simply ends with the stream.
        send_text("\"a", 1'b1);

        // Random streams. Each stream draws its own idle setting so there
        // are calm stretches, and the last part of the run has no idling.
        random_goal = words_sent + RANDOM_WORDS;
        while (words_sent < random_goal) begin
            no_idle <= (words_sent > random_goal - 100) || ($urandom_range(0, 4) == 0);
            build_stream();
            foreach (text_q[i])
                send_word(text_q[i], i == text_q.size() - 1);
        end
        push <= 1'b0;

        // Let the prediction of the final word land before testing pending.
        do
            @(posedge clk);
        while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("tb_comment_strip_space_collapse: PASS");
        else
            $display("tb_comment_strip_space_collapse: FAIL");
        $finish;
    end

endmodule
